// File: hdl/gytc_pkg.sv
// ----------------------------------------------------------------------------
// gytc_pkg
// Shared types and constants of the gimbal yaw tracking controller.
// ----------------------------------------------------------------------------
package gytc_pkg;

    // widths fixed by the item fields
    localparam int unsigned ANG_W    = 16;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned SPD_W    = 24;
    localparam int unsigned SRC_W    = 3;
    localparam int unsigned CORD_W   = 27;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned CFG_IW   = 3;
    localparam int unsigned CFG_DW   = 23;
    localparam int unsigned IN_W     = 152;
    localparam int unsigned OUT_W    = 32;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_GAIN      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SPD_LIMIT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_YAW_TOL   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SMOOTHING = 3'd3;
    localparam logic [CFG_IW-1:0] REG_MAX_STEP  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ZERO_BAND = 3'd5;

    // target source codes
    localparam logic [SRC_W-1:0] SRC_NONE     = 3'd0;
    localparam logic [SRC_W-1:0] SRC_OVERRIDE = 3'd1;
    localparam logic [SRC_W-1:0] SRC_GOAL_YAW = 3'd2;
    localparam logic [SRC_W-1:0] SRC_HEADING  = 3'd3;
    localparam logic [SRC_W-1:0] SRC_HELD     = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic             err;
        logic             mul;
        logic             fin;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_full;
    } t_sts;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic [31:0] atan_lut(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/gytc_ctrl.sv
// ----------------------------------------------------------------------------
// gytc_ctrl
// Sequencer: accept, cordic iterations, error and gain, smoothing, write back.
// ----------------------------------------------------------------------------
module gytc_ctrl #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gytc_pkg::t_sts  i_sts,
    output gytc_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_ERR,
        S_MUL,
        S_FIN
    } t_state;

    localparam logic [gytc_pkg::IDX_W-1:0] LAST_IDX = gytc_pkg::IDX_W'(CORDIC_STEPS - 1);

    t_state                      r_state, n_state;
    logic [gytc_pkg::IDX_W-1:0]  r_idx, n_idx;

    // command decode
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step = (r_state == S_CORDIC);
        o_cmd.err  = (r_state == S_ERR);
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.fin  = (r_state == S_FIN) && !i_sts.out_full;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_ERR;
                end
            end
            S_ERR:   n_state = S_MUL;
            S_MUL:   n_state = S_FIN;
            S_FIN: begin
                if (!i_sts.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CORDIC) && (r_idx == '0))
        else $error("accepted item did not start the cordic");
    a_cordic_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) && (r_idx == LAST_IDX) |=> (r_state == S_ERR))
        else $error("cordic ran past its last step");
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && i_sts.out_full |=> (r_state == S_FIN))
        else $error("write back left while output full");
`endif

endmodule

// File: hdl/gytc_dp.sv
// ----------------------------------------------------------------------------
// gytc_dp
// Datapath: registers, target selection, cordic atan2, gain, smoothing.
// ----------------------------------------------------------------------------
module gytc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gytc_pkg::CFG_IW-1:0]        i_cfg_idx,
    input  logic [gytc_pkg::CFG_DW-1:0]        i_cfg_data,
    input  logic [gytc_pkg::IN_W-1:0]          i_in_data,
    input  gytc_pkg::t_cmd                     i_cmd,
    output gytc_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gytc_pkg::OUT_W-1:0]         o_out_data
);

    localparam int unsigned CW = gytc_pkg::CORD_W;

    // configuration
    logic [15:0] r_gain;
    logic [22:0] r_spd_limit;
    logic [14:0] r_yaw_tol;
    logic [16:0] r_smoothing;
    logic [22:0] r_max_step;
    logic [15:0] r_zero_band;

    // state
    logic signed [23:0] r_speed;
    logic [15:0]        r_held_yaw;
    logic               r_held_valid;

    // item registers
    logic [15:0]        r_cur;
    logic               r_cur_ok;
    logic [2:0]         r_src;
    logic [15:0]        r_target;
    logic               r_zero_vec;
    logic signed [CW-1:0] r_x, r_y;
    logic [31:0]        r_ang;
    logic signed [33:0] r_prod1;
    logic signed [42:0] r_prod2;
    logic               r_out_valid;
    logic [gytc_pkg::OUT_W-1:0] r_out_data;

    // input field unpack
    logic [15:0] in_cur, in_ovr, in_gy;
    logic        in_cur_ok, in_ovr_ok, in_gy_ok, in_gxy_ok, in_pos_ok;
    logic signed [23:0] in_gx, in_gyy, in_px, in_py;
    assign in_cur    = i_in_data[15:0];
    assign in_cur_ok = i_in_data[16];
    assign in_ovr_ok = i_in_data[17];
    assign in_ovr    = i_in_data[33:18];
    assign in_gy_ok  = i_in_data[34];
    assign in_gy     = i_in_data[50:35];
    assign in_gxy_ok = i_in_data[51];
    assign in_gx     = i_in_data[75:52];
    assign in_gyy    = i_in_data[99:76];
    assign in_pos_ok = i_in_data[100];
    assign in_px     = i_in_data[124:101];
    assign in_py     = i_in_data[148:125];

    // source selection and cordic pre-rotation
    logic [2:0]         sel_src;
    logic [15:0]        sel_target;
    logic signed [24:0] dx, dy;
    logic signed [CW-1:0] pre_x, pre_y;
    logic [31:0]        pre_ang;
    always_comb begin
        dx = 25'(in_gx) - 25'(in_px);
        dy = 25'(in_gyy) - 25'(in_py);
        sel_target = r_held_yaw;
        if (in_ovr_ok) begin
            sel_src = gytc_pkg::SRC_OVERRIDE;
            sel_target = in_ovr;
        end else if (in_gy_ok) begin
            sel_src = gytc_pkg::SRC_GOAL_YAW;
            sel_target = in_gy;
        end else if (in_gxy_ok && in_pos_ok) begin
            sel_src = gytc_pkg::SRC_HEADING;
        end else if (r_held_valid) begin
            sel_src = gytc_pkg::SRC_HELD;
        end else begin
            sel_src = gytc_pkg::SRC_NONE;
        end
        pre_x   = CW'(dx);
        pre_y   = CW'(dy);
        pre_ang = 32'h0000_0000;
        if (dx < 0) begin
            if (dy >= 0) begin
                pre_x   = CW'(dy);
                pre_y   = -CW'(dx);
                pre_ang = 32'h4000_0000;
            end else begin
                pre_x   = -CW'(dy);
                pre_y   = CW'(dx);
                pre_ang = 32'hC000_0000;
            end
        end
    end

    // one cordic vectoring step
    logic signed [CW-1:0] xs, ys;
    assign xs = r_x >>> i_cmd.idx;
    assign ys = r_y >>> i_cmd.idx;

    // yaw error and release test
    logic [31:0]        ang_rnd;
    logic [15:0]        tgt;
    logic [15:0]        e_raw;
    logic signed [16:0] e;
    logic [16:0]        ae;
    logic               in_band, have, nav, release_held;
    always_comb begin
        ang_rnd = r_ang + 32'h0000_8000;
        if (r_src == gytc_pkg::SRC_HEADING) begin
            tgt = r_zero_vec ? 16'h0000 : ang_rnd[31:16];
        end else begin
            tgt = r_target;
        end
        e_raw   = tgt - r_cur;
        e       = 17'($signed(e_raw));
        ae      = e[16] ? 17'(-e) : 17'(e);
        in_band = (ae <= {2'b00, r_yaw_tol});
        have    = (r_src != gytc_pkg::SRC_NONE);
        nav     = (r_src == gytc_pkg::SRC_GOAL_YAW) || (r_src == gytc_pkg::SRC_HEADING);
        release_held = (r_src == gytc_pkg::SRC_HELD) && r_cur_ok && in_band;
    end

    // clamp of the target speed and difference to previous
    logic signed [25:0] tsp;
    logic signed [25:0] lim;
    logic signed [23:0] tclamp;
    logic signed [24:0] diff;
    logic [16:0]        alpha;
    always_comb begin
        tsp = r_prod1[33:8];
        lim = 26'($signed({1'b0, r_spd_limit}));
        if (tsp > lim) begin
            tclamp = 24'(lim);
        end else if (tsp < -lim) begin
            tclamp = 24'(-lim);
        end else begin
            tclamp = 24'(tsp);
        end
        diff  = 25'(tclamp) - 25'(r_speed);
        alpha = (r_smoothing > 17'd65536) ? 17'd65536 : r_smoothing;
    end

    // slew limit and zero band
    logic signed [26:0] d_raw, d_lim, stp, f27;
    logic signed [23:0] f;
    logic [23:0]        af;
    logic signed [23:0] f_out;
    always_comb begin
        d_raw = r_prod2[42:16];
        stp   = 27'($signed({1'b0, r_max_step}));
        d_lim = d_raw;
        if (r_max_step != '0) begin
            if (d_raw > stp) begin
                d_lim = stp;
            end else if (d_raw < -stp) begin
                d_lim = -stp;
            end
        end
        f27   = 27'(r_speed) + d_lim;
        f     = 24'(f27);
        af    = f[23] ? 24'(-f) : 24'(f);
        f_out = (af < {8'd0, r_zero_band}) ? 24'sd0 : f;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= 16'd322;
            r_spd_limit  <= 23'd32768;
            r_yaw_tol    <= 15'd1456;
            r_smoothing  <= 17'd1311;
            r_max_step   <= 23'd66;
            r_zero_band  <= 16'd7;
            r_speed      <= '0;
            r_held_yaw   <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gytc_pkg::REG_GAIN:      r_gain      <= i_cfg_data[15:0];
                    gytc_pkg::REG_SPD_LIMIT: r_spd_limit <= i_cfg_data[22:0];
                    gytc_pkg::REG_YAW_TOL:   r_yaw_tol   <= i_cfg_data[14:0];
                    gytc_pkg::REG_SMOOTHING: r_smoothing <= i_cfg_data[16:0];
                    gytc_pkg::REG_MAX_STEP:  r_max_step  <= i_cfg_data[22:0];
                    gytc_pkg::REG_ZERO_BAND: r_zero_band <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.err) begin
                if (nav) begin
                    r_held_yaw   <= tgt;
                    r_held_valid <= 1'b1;
                end else if (release_held) begin
                    r_held_valid <= 1'b0;
                end
            end
            if (i_cmd.fin) begin
                r_speed     <= f_out;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur      <= in_cur;
            r_cur_ok   <= in_cur_ok;
            r_src      <= sel_src;
            r_target   <= sel_target;
            r_zero_vec <= (dx == '0) && (dy == '0);
            r_x        <= pre_x;
            r_y        <= pre_y;
            r_ang      <= pre_ang;
        end
        if (i_cmd.step) begin
            if (r_y > 0) begin
                r_x   <= r_x + ys;
                r_y   <= r_y - xs;
                r_ang <= r_ang + gytc_pkg::atan_lut(i_cmd.idx);
            end else begin
                r_x   <= r_x - ys;
                r_y   <= r_y + xs;
                r_ang <= r_ang - gytc_pkg::atan_lut(i_cmd.idx);
            end
        end
        if (i_cmd.err) begin
            if (have && r_cur_ok && !in_band) begin
                r_prod1 <= $signed({1'b0, r_gain}) * e;
            end else begin
                r_prod1 <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_prod2 <= $signed({1'b0, alpha}) * diff;
        end
        if (i_cmd.fin) begin
            r_out_data <= {4'd0, r_held_valid, r_src, f_out};
        end
    end

    assign o_sts.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

`ifndef SYNTHESIS
    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_out_valid)
        else $error("finished item not presented");
    a_nav_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.err && nav |=> r_held_valid)
        else $error("goal target not held");
    a_out_zero_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin && (af < {8'd0, r_zero_band}) |=> (r_speed == '0))
        else $error("speed inside zero band not cleared");
`endif

endmodule

// File: hdl/gimbal_yaw_tracking_controller_unit.sv
// ----------------------------------------------------------------------------
// gimbal_yaw_tracking_controller_unit
// Yaw tracking speed controller, one item per control tick.
// ----------------------------------------------------------------------------
// After an item is accepted, with the pre-rotated vector loaded at the
// accepting edge, the cordic atan2 runs one step per cycle, then the
// error and gain multiply, the smoothing multiply, and write back follow.
// The input is ready again in the cycle the result appears, so a new item
// is accepted only once the last one is written back. One item is in
// work at a time; a finished result waits in the output register while
// the next item is accepted, and write back stalls while that register
// is still full. Config is to be written only while idle; the block
// itself does not enforce it. Indexes above five are ignored.
module gimbal_yaw_tracking_controller_unit #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gytc_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [gytc_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // measured yaw, measured yaw ok, override ok, override target,
    // goal heading ok, goal heading, goal position ok, goal x, goal y,
    // position ok, position x, position y, zero pad
    input  logic [gytc_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // yaw_speed, target_source, holding, zero pad
    output logic [gytc_pkg::OUT_W-1:0]  m_axis_tdata
);

    gytc_pkg::t_cmd cmd;
    gytc_pkg::t_sts sts;

    gytc_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gytc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
